FILE: rtl/bve_pkg.sv
// ----------------------------------------------------------------------------
// bve_pkg: shared types and constants for the bijective varint encoder
// Holds the queued item format, the queue status group and default sizes.
// ----------------------------------------------------------------------------
package bve_pkg;

	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned GROUP_W     = 7;
	localparam int unsigned QUEUE_DEPTH = 2;

	// value as accepted, plus the front's classification
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               single;   // value below 128: one byte only
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BACK_IDLE = 2'b01,
		BACK_RUN  = 2'b10
	} back_state_t;

endpackage

FILE: rtl/bve_front.sv
// ----------------------------------------------------------------------------
// bve_front: command front end
// Accepts a value, classifies it as one-byte or multi-byte and holds it in
// one stage until the queue takes it.
// ----------------------------------------------------------------------------
module bve_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bve_pkg::VALUE_W-1:0]   value,
	output logic                          busy,
	input  bve_pkg::q_status_t            q_status,
	output logic                          push,
	output bve_pkg::item_t                push_item
);

	logic           valid_s1;
	bve_pkg::item_t item_s1;
	logic           accept;

	assign push   = valid_s1 && !q_status.full;
	assign busy   = valid_s1 && q_status.full;
	assign accept = start && !busy;

	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.value  <= value;
			item_s1.single <= (value[bve_pkg::VALUE_W-1:bve_pkg::GROUP_W] == '0);
		end
	end

endmodule

FILE: rtl/bve_queue.sv
// ----------------------------------------------------------------------------
// bve_queue: short item queue between front and back
// Register-based FIFO; the read entry is visible while not empty.
// ----------------------------------------------------------------------------
module bve_queue #(
	parameter int unsigned DEPTH = bve_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bve_pkg::item_t     push_item,
	input  logic               pop,
	output bve_pkg::item_t     pop_item,
	output bve_pkg::q_status_t status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bve_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/bve_back.sv
// ----------------------------------------------------------------------------
// bve_back: byte emitter
// Takes queued values and emits one encoded byte per cycle while running,
// reducing the remaining value after every byte that has more to follow.
// ----------------------------------------------------------------------------
module bve_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bve_pkg::q_status_t           q_status,
	input  bve_pkg::item_t               pop_item,
	output logic                         pop,
	output logic                         strobe,
	output logic [bve_pkg::BYTE_W-1:0]   code_byte,
	output logic                         last_byte
);

	localparam int unsigned VW = bve_pkg::VALUE_W;
	localparam int unsigned GW = bve_pkg::GROUP_W;

	bve_pkg::back_state_t state_q;
	logic [VW-1:0]        rem_q;
	logic                 more_q;
	logic [VW-1:0]        next_rem;
	logic                 running;

	assign running = (state_q == bve_pkg::BACK_RUN);

	// (rem - low - 128) / 128 == (rem >> 7) - 1, as the low group drops out
	assign next_rem = {{GW{1'b0}}, rem_q[VW-1:GW]} - VW'(1);

	assign pop = (!running || !more_q) && !q_status.empty;

	assign strobe    = running;
	assign code_byte = {more_q, rem_q[GW-1:0]};
	assign last_byte = !more_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bve_pkg::BACK_IDLE;
		end else begin
			unique case (state_q)
				bve_pkg::BACK_IDLE: begin
					if (pop) begin
						state_q <= bve_pkg::BACK_RUN;
					end
				end
				bve_pkg::BACK_RUN: begin
					if (!more_q && !pop) begin
						state_q <= bve_pkg::BACK_IDLE;
					end
				end
				default: begin
					state_q <= bve_pkg::BACK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q  <= pop_item.value;
			more_q <= !pop_item.single;
		end else if (running && more_q) begin
			rem_q  <= next_rem;
			more_q <= (next_rem[VW-1:GW] != '0);
		end
	end

	// a value's bytes come out without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_byte |=> strobe)
		else $error("gap inside one value's byte sequence");

	// next value follows straight on when one is queued
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_byte && !q_status.empty |=> strobe)
		else $error("queued value not started after last byte");

	// never pop while a value still has bytes to go
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(running && more_q))
		else $error("pop during an unfinished value");

endmodule

FILE: rtl/bijective_varint_encoder.sv
// ----------------------------------------------------------------------------
// bijective_varint_encoder: little-endian bijective base-128 encoder
// Encodes a 64-bit value into one to ten bytes, lowest group first.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   command  | start / busy         | value[63:0]
//   result   | strobe (no stall)    | code_byte[7:0], last_byte
//
// The emitter sends a value of n bytes (1..10) one byte at a time; its
// single reduce-by-128 step per cycle sets this pace.
// The first byte passes through the front stage and the queue; values
// follow one another without a gap while the next one is queued.
// busy rises when the front stage and the queue are all occupied.
// Reset clears the front stage, queue pointers and emitter state.
// ----------------------------------------------------------------------------
module bijective_varint_encoder #(
	parameter int unsigned QUEUE_DEPTH = bve_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bve_pkg::VALUE_W-1:0]  value,
	output logic                         strobe,
	output logic [bve_pkg::BYTE_W-1:0]   code_byte,
	output logic                         last_byte
);

	bve_pkg::q_status_t q_status;
	bve_pkg::item_t     push_item;
	bve_pkg::item_t     pop_item;
	logic               push;
	logic               pop;

	bve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	bve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	bve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_item  (pop_item),
		.pop       (pop),
		.strobe    (strobe),
		.code_byte (code_byte),
		.last_byte (last_byte)
	);

endmodule
